FILE: rtl/bki_pkg.sv
package bki_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int VALUE_W = 32;
   localparam int OP_W = 2;
   localparam int SLOT_W = 6;
   localparam int ORDER_W = 4;
   localparam int COUNT_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 6;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_ORDINATES = 32;
   localparam int DEF_MAX_ORDER = 8;
   localparam int DEF_FRAC_BITS = 16;

   // Reset values of the configuration registers.
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOAD_KNOT = 2'd0;
   localparam op_type OP_LOAD_ORD = 2'd1;
   localparam op_type OP_INSERT = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_SPLINE_ORDER = 2'd0;
   localparam csr_index_type REG_ORDINATE_COUNT = 2'd1;

   typedef struct packed {
      op_type operation;
      logic [SLOT_W-1:0] slot;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] out_index;
      logic signed [VALUE_W-1:0] refined;
      logic final_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_CAPTURE,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/bki_div.sv
// Restoring divider, one quotient bit per cycle. The dividend is strictly
// smaller than the divisor, so the quotient has FRAC_BITS bits.
module bki_div #(
   parameter int FRAC_BITS = bki_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bki_pkg::VALUE_W:0]      num,
   input  logic [bki_pkg::VALUE_W:0]      den,
   output logic [FRAC_BITS-1:0]           quotient,
   output logic                           done
);

   localparam int RW = bki_pkg::VALUE_W + 2;
   localparam int CW = $clog2(FRAC_BITS);

   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-2:0] den_ff, den_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [RW-1:0] twice;
   logic fits;

   always_comb begin
      twice = {rem_ff[RW-2:0], 1'b0};
      fits = (twice >= {1'b0, den_ff});
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, num};
         den_in = den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (twice - {1'b0, den_ff}) : twice;
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

FILE: rtl/bki_mul.sv
// Two shift-add multipliers run side by side, one weight bit per cycle,
// followed by the floor shift, the sum and signed saturation.
module bki_mul #(
   parameter int FRAC_BITS = bki_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [FRAC_BITS:0]                  wa,
   input  logic [FRAC_BITS:0]                  wb,
   input  logic signed [bki_pkg::VALUE_W-1:0]  a,
   input  logic signed [bki_pkg::VALUE_W-1:0]  b,
   output logic signed [bki_pkg::VALUE_W-1:0]  blend,
   output logic                                done
);

   localparam int VW = bki_pkg::VALUE_W;
   localparam int WW = FRAC_BITS + 1;
   localparam int PW = VW + WW;
   localparam int CW = $clog2(WW);
   localparam int SW = VW + 2;

   logic [FRAC_BITS:0] wa_ff, wa_in, wb_ff, wb_in;
   logic signed [PW-1:0] mca_ff, mca_in, mcb_ff, mcb_in;
   logic signed [PW-1:0] acca_ff, acca_in, accb_ff, accb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [PW-1:0] sha, shb;
   logic signed [SW-1:0] sum;

   always_comb begin
      wa_in = wa_ff;
      wb_in = wb_ff;
      mca_in = mca_ff;
      mcb_in = mcb_ff;
      acca_in = acca_ff;
      accb_in = accb_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         wa_in = wa;
         wb_in = wb;
         mca_in = PW'(a);
         mcb_in = PW'(b);
         acca_in = '0;
         accb_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (wa_ff[0]) acca_in = acca_ff + mca_ff;
         if (wb_ff[0]) accb_in = accb_ff + mcb_ff;
         wa_in = wa_ff >> 1;
         wb_in = wb_ff >> 1;
         mca_in = mca_ff <<< 1;
         mcb_in = mcb_ff <<< 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      mca_ff <= mca_in;
      mcb_ff <= mcb_in;
      acca_ff <= acca_in;
      accb_ff <= accb_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Each product is floored on its own before the sum is taken.
   always_comb begin
      sha = acca_ff >>> FRAC_BITS;
      shb = accb_ff >>> FRAC_BITS;
      sum = SW'(signed'(sha[VW:0])) + SW'(signed'(shb[VW:0]));
      if (sum > $signed(SW'({1'b0, {(VW-1){1'b1}}}))) begin
         blend = {1'b0, {(VW-1){1'b1}}};
      end else if (sum < -(SW'(1) <<< (VW - 1))) begin
         blend = {1'b1, {(VW-1){1'b0}}};
      end else begin
         blend = sum[VW-1:0];
      end
   end

   assign done = done_ff;

endmodule

FILE: rtl/bspline_knot_insertion_top.sv
// B-spline knot insertion (Boehm) in signed fixed point, Q16.16 by default.
// Load transactions write one knot or one control ordinate into on-chip
// stores; they give no result. An insert transaction with knot value x
// gives ordinate_count+1 result transactions, in index order, the last one
// marked by final_res. The two end results copy the first and last
// ordinates. Every inner result reads two knots and two ordinates, forms its
// weight with a bit-serial divider (skipped when the weight is exactly zero
// or one) and blends the two ordinates with bit-serial multipliers. An insert
// stalls while a result waits in the output register with rsp_ready low.
// Reads of store entries that were never loaded return undefined data.
// Register writes take effect on the next insert; out-of-range order and
// count values are clamped at use.
module bspline_knot_insertion_top #(
   parameter int MAX_ORDINATES = bki_pkg::DEF_MAX_ORDINATES,
   parameter int MAX_ORDER = bki_pkg::DEF_MAX_ORDER,
   parameter int FRAC_BITS = bki_pkg::DEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bki_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bki_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  bki_pkg::csr_index_type               csr_index,
   input  logic [bki_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int VW = bki_pkg::VALUE_W;
   localparam int KNOT_DEPTH = MAX_ORDINATES + MAX_ORDER;
   localparam int KA_W = $clog2(KNOT_DEPTH);
   localparam int OA_W = $clog2(MAX_ORDINATES);
   localparam int IDX_W = $clog2(MAX_ORDINATES + 1);
   localparam int K_W = $clog2(MAX_ORDER + 1);

   // Configuration registers. The write channel never stalls.
   logic [bki_pkg::ORDER_W-1:0] order_ff;
   logic [bki_pkg::COUNT_W-1:0] count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= bki_pkg::ORDER_RESET;
         count_ff <= bki_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bki_pkg::REG_SPLINE_ORDER: order_ff <= csr_data[bki_pkg::ORDER_W-1:0];
            bki_pkg::REG_ORDINATE_COUNT: count_ff <= csr_data[bki_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state.
   bki_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [K_W-1:0] k_ff, k_in;
   logic signed [VW-1:0] x_ff, x_in;
   logic signed [VW-1:0] lo_ff, lo_in;
   logic signed [VW-1:0] a_ff, a_in;
   logic signed [VW-1:0] b_ff, b_in;
   logic endpoint_ff, endpoint_in;
   logic rsp_valid_ff, rsp_valid_in;
   bki_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Stores, one read port and one write port each, registered read data.
   logic signed [VW-1:0] knot_mem [KNOT_DEPTH];
   logic signed [VW-1:0] ord_mem [MAX_ORDINATES];
   logic signed [VW-1:0] knot_rd_ff;
   logic signed [VW-1:0] ord_rd_ff;
   logic [KA_W-1:0] knot_addr;
   logic [OA_W-1:0] ord_addr;

   logic req_fire;
   logic knot_we, ord_we;

   assign req_ready = (state_ff == bki_pkg::ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign knot_we = req_fire && (req_data.operation == bki_pkg::OP_LOAD_KNOT)
                    && ({1'b0, req_data.slot} < 7'(KNOT_DEPTH));
   assign ord_we = req_fire && (req_data.operation == bki_pkg::OP_LOAD_ORD)
                   && ({1'b0, req_data.slot} < 7'(MAX_ORDINATES));

   always_ff @(posedge clock) begin
      if (knot_we) knot_mem[KA_W'(req_data.slot)] <= req_data.value;
      if (ord_we) ord_mem[OA_W'(req_data.slot)] <= req_data.value;
      knot_rd_ff <= knot_mem[knot_addr];
      ord_rd_ff <= ord_mem[ord_addr];
   end

   // Serial arithmetic units.
   logic div_start, div_done;
   logic [VW:0] div_num, div_den;
   logic [FRAC_BITS-1:0] div_q;
   logic mul_start, mul_done;
   logic [FRAC_BITS:0] w_sel, wa_sel;
   logic signed [VW-1:0] b_sel;
   logic signed [VW-1:0] mul_blend;

   bki_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .quotient (div_q),
      .done     (div_done)
   );

   bki_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .wa    (wa_sel),
      .wb    (w_sel),
      .a     (a_ff),
      .b     (b_sel),
      .blend (mul_blend),
      .done  (mul_done)
   );

   localparam logic [FRAC_BITS:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

   logic [K_W:0] k_clamp;
   logic [IDX_W:0] n_clamp;
   logic [KA_W:0] hi_addr;
   logic signed [VW:0] diff_x, diff_k;
   logic x_le_lo, x_ge_hi;
   logic out_free;

   always_comb begin
      // Register values are clamped when an insert is taken.
      if ({{K_W{1'b0}}, order_ff} < (K_W + bki_pkg::ORDER_W)'(2)) begin
         k_clamp = (K_W + 1)'(2);
      end else if ({{K_W{1'b0}}, order_ff} > (K_W + bki_pkg::ORDER_W)'(MAX_ORDER)) begin
         k_clamp = (K_W + 1)'(MAX_ORDER);
      end else begin
         k_clamp = (K_W + 1)'(order_ff);
      end
      if (count_ff == '0) begin
         n_clamp = (IDX_W + 1)'(1);
      end else if ({{IDX_W{1'b0}}, count_ff} > (IDX_W + bki_pkg::COUNT_W)'(MAX_ORDINATES)) begin
         n_clamp = (IDX_W + 1)'(MAX_ORDINATES);
      end else begin
         n_clamp = (IDX_W + 1)'(count_ff);
      end

      hi_addr = (KA_W + 1)'(idx_ff) + (KA_W + 1)'(k_ff) - (KA_W + 1)'(1);
      diff_x = {x_ff[VW-1], x_ff} - {lo_ff[VW-1], lo_ff};
      diff_k = {knot_rd_ff[VW-1], knot_rd_ff} - {lo_ff[VW-1], lo_ff};
      x_le_lo = (x_ff <= lo_ff);
      x_ge_hi = (x_ff >= knot_rd_ff);
      out_free = !rsp_valid_ff || rsp_ready;

      state_in = state_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      k_in = k_ff;
      x_in = x_ff;
      lo_in = lo_ff;
      a_in = a_ff;
      b_in = b_ff;
      endpoint_in = endpoint_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      knot_addr = KA_W'(idx_ff);
      ord_addr = (idx_ff == '0) ? '0 : OA_W'(idx_ff - IDX_W'(1));
      div_start = 1'b0;
      div_num = diff_x[VW:0];
      div_den = diff_k[VW:0];
      mul_start = 1'b0;
      w_sel = x_le_lo ? '0 : ONE_W;
      b_sel = ord_rd_ff;

      case (state_ff)
         bki_pkg::ST_IDLE: begin
            if (req_fire && (req_data.operation == bki_pkg::OP_INSERT)) begin
               idx_in = '0;
               k_in = K_W'(k_clamp);
               n_in = IDX_W'(n_clamp);
               x_in = req_data.value;
               state_in = bki_pkg::ST_FETCH_A;
            end
         end
         bki_pkg::ST_FETCH_A: begin
            state_in = bki_pkg::ST_FETCH_B;
         end
         bki_pkg::ST_FETCH_B: begin
            // Second read: the upper knot and the right-hand ordinate.
            knot_addr = KA_W'(hi_addr);
            ord_addr = OA_W'(idx_ff);
            lo_in = knot_rd_ff;
            a_in = ord_rd_ff;
            if (idx_ff == '0 || idx_ff == n_ff) begin
               endpoint_in = 1'b1;
               state_in = bki_pkg::ST_EMIT;
            end else begin
               endpoint_in = 1'b0;
               state_in = bki_pkg::ST_CAPTURE;
            end
         end
         bki_pkg::ST_CAPTURE: begin
            b_in = ord_rd_ff;
            if (x_le_lo || x_ge_hi) begin
               mul_start = 1'b1;
               state_in = bki_pkg::ST_MUL;
            end else begin
               div_start = 1'b1;
               state_in = bki_pkg::ST_DIV;
            end
         end
         bki_pkg::ST_DIV: begin
            w_sel = {1'b0, div_q};
            b_sel = b_ff;
            if (div_done) begin
               mul_start = 1'b1;
               state_in = bki_pkg::ST_MUL;
            end
         end
         bki_pkg::ST_MUL: begin
            if (mul_done) state_in = bki_pkg::ST_EMIT;
         end
         bki_pkg::ST_EMIT: begin
            // The output register takes the result once it is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_index = bki_pkg::COUNT_W'(idx_ff);
               rsp_data_in.refined = endpoint_ff ? a_ff : mul_blend;
               rsp_data_in.final_res = (idx_ff == n_ff);
               if (idx_ff == n_ff) begin
                  state_in = bki_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  state_in = bki_pkg::ST_FETCH_A;
               end
            end
         end
         default: state_in = bki_pkg::ST_IDLE;
      endcase

      wa_sel = ONE_W - w_sel;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      k_ff <= k_in;
      x_ff <= x_in;
      lo_ff <= lo_in;
      a_ff <= a_in;
      b_ff <= b_in;
      endpoint_ff <= endpoint_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= bki_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
